/* hdl/isei_pkg.sv */
// types, constants and sequencer states for the expected-impact block
// no dependencies; used by the channel interfaces and the top level
package isei_pkg;

    // probability format
    localparam int PROB_FRAC_BITS = 16;
    localparam int PROB_W         = PROB_FRAC_BITS + 1;

    // item field widths
    localparam int TIME_W    = 32;
    localparam int IMP_W     = 32;
    localparam int DETECT_W  = 17;
    localparam int SUM_W     = 48;
    localparam int TOTAL_W   = 64;

    // shared multiplier and adder widths
    localparam int MUL_W = IMP_W + PROB_W;
    localparam int ADD_W = ((MUL_W > SUM_W) ? MUL_W : SUM_W) + 1;
    localparam int CMP_W = (DETECT_W > PROB_W) ? DETECT_W : PROB_W;

    typedef logic [PROB_W-1:0] prob_t;

    localparam prob_t PROB_ONE = {1'b1, {PROB_FRAC_BITS{1'b0}}};
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic [TIME_W-1:0]   arrival_time;
        logic [IMP_W-1:0]    node_impact;
        logic [DETECT_W-1:0] detect_prob;
        logic                sensor_placed;
        logic                is_dummy;
        logic                last_in_scenario;
        logic                last_scenario;
    } in_item_t;

    typedef struct packed {
        logic [SUM_W-1:0]   scenario_impact;
        logic [TOTAL_W-1:0] total_impact;
        logic               batch_done;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_DET,
        S_MUL_IMP,
        S_ACC,
        S_OPEN,
        S_MISS,
        S_BATCH,
        S_EMIT
    } seq_state_t;

endpackage

/* hdl/isei_if.sv */
// valid/ready channels for arrival entries and scenario results
// depends on isei_pkg for the payload structs
interface isei_in_if;
    import isei_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface isei_out_if;
    import isei_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/imperfect_sensor_expected_impact.sv */
// expected impact of contamination scenarios under imperfect sensors
// depends on isei_pkg and the channel interfaces in isei_if.sv
//
//  channel   dir  payload                                   item
//  in_ch     in   time, impact, prob, placed, dummy, lasts   one arrival entry
//  out_ch    out  scenario_impact, total_impact, batch_done  one scenario result
//
// one multiplier is shared under a small sequencer; in_ch.ready is high only in idle.
// an entry inside a group passes idle and S_OPEN (and S_MISS with a placed sensor); closing a
// detectable group adds S_MUL_DET, S_MUL_IMP and S_ACC; a scenario end adds S_BATCH and S_EMIT.
// rst_n clears all control and sums at once; no clearing pass.
// a result waits in the output register; the next item is taken meanwhile, and the
// sequencer holds only if a second result is ready before the first is taken.
module imperfect_sensor_expected_impact (
    input  logic              clk,
    input  logic              rst_n,
    isei_in_if.sink           in_ch,
    isei_out_if.source        out_ch
);
    import isei_pkg::*;

    seq_state_t state_reg, state_next;

    // captured entry
    logic [TIME_W-1:0] t_reg, t_next;
    logic [IMP_W-1:0]  imp_reg, imp_next;
    prob_t             p_reg, p_next;
    logic              placed_reg, placed_next;
    logic              dummy_reg, dummy_next;
    logic              last_reg, last_next;
    logic              lscen_reg, lscen_next;
    logic              final_reg, final_next;

    // group and scenario state
    logic [TIME_W-1:0]  group_time_reg, group_time_next;
    logic [IMP_W-1:0]   group_impact_reg, group_impact_next;
    prob_t              group_miss_reg, group_miss_next;
    logic               group_det_reg, group_det_next;
    logic               group_open_reg, group_open_next;
    logic [SUM_W-1:0]   scen_sum_reg, scen_sum_next;
    prob_t              remain_reg, remain_next;
    logic [TOTAL_W-1:0] batch_sum_reg, batch_sum_next;

    // shared multiplier
    logic [IMP_W-1:0] mul_a;
    prob_t            mul_b;
    logic [MUL_W-1:0] prod_reg, prod_next;
    prob_t            taken_reg, taken_next;

    // output register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    // decisions and wide sums for the control blocks
    logic             close_now;
    logic             open_det;
    logic             need_mul;
    logic             out_free;
    prob_t            p_clamped;
    logic [ADD_W-1:0] sum_wide;
    logic [TOTAL_W:0] batch_wide;

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    assign close_now = group_open_reg && (in_ch.data.arrival_time != group_time_reg);
    assign open_det  = (group_open_reg && group_det_reg) || dummy_reg || placed_reg;
    assign need_mul  = placed_reg && !dummy_reg;
    assign out_free  = !out_valid_reg || out_ch.ready;

    // probability above one is taken as one
    assign p_clamped = (CMP_W'(in_ch.data.detect_prob) > CMP_W'(PROB_ONE))
                     ? PROB_ONE : PROB_W'(in_ch.data.detect_prob);

    assign sum_wide   = ADD_W'(scen_sum_reg) + ADD_W'(prod_reg);
    assign batch_wide = (TOTAL_W + 1)'(batch_sum_reg) + (TOTAL_W + 1)'(scen_sum_reg);

    assign prod_next = MUL_W'(mul_a) * MUL_W'(mul_b);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (close_now && group_det_reg)
                        state_next = S_MUL_DET;
                    else
                        state_next = S_OPEN;
                end
            end
            S_MUL_DET: state_next = S_MUL_IMP;
            S_MUL_IMP: state_next = S_ACC;
            S_ACC:     state_next = final_reg ? S_BATCH : S_OPEN;
            S_OPEN:
            begin
                if (need_mul)
                    state_next = S_MISS;
                else if (!last_reg)
                    state_next = S_IDLE;
                else if (open_det)
                    state_next = S_MUL_DET;
                else
                    state_next = S_BATCH;
            end
            S_MISS:    state_next = last_reg ? S_MUL_DET : S_IDLE;
            S_BATCH:   state_next = S_EMIT;
            S_EMIT:    state_next = out_free ? S_IDLE : S_EMIT;
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        t_next            = t_reg;
        imp_next          = imp_reg;
        p_next            = p_reg;
        placed_next       = placed_reg;
        dummy_next        = dummy_reg;
        last_next         = last_reg;
        lscen_next        = lscen_reg;
        final_next        = final_reg;
        group_time_next   = group_time_reg;
        group_impact_next = group_impact_reg;
        group_miss_next   = group_miss_reg;
        group_det_next    = group_det_reg;
        group_open_next   = group_open_reg;
        scen_sum_next     = scen_sum_reg;
        remain_next       = remain_reg;
        batch_sum_next    = batch_sum_reg;
        taken_next        = taken_reg;
        mul_a             = IMP_W'(remain_reg);
        mul_b             = PROB_ONE - group_miss_reg;
        out_data_next     = out_data_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    t_next      = in_ch.data.arrival_time;
                    imp_next    = in_ch.data.node_impact;
                    p_next      = p_clamped;
                    placed_next = in_ch.data.sensor_placed;
                    dummy_next  = in_ch.data.is_dummy;
                    last_next   = in_ch.data.last_in_scenario;
                    lscen_next  = in_ch.data.last_scenario;
                    final_next  = 1'b0;
                    // a group with no possible detection just closes
                    if (close_now && !group_det_reg)
                        group_open_next = 1'b0;
                end
            end
            // remaining times detection
            S_MUL_DET:
            begin
                mul_a = IMP_W'(remain_reg);
                mul_b = PROB_ONE - group_miss_reg;
            end
            // impact times taken share
            S_MUL_IMP:
            begin
                taken_next = prod_reg[PROB_FRAC_BITS +: PROB_W];
                mul_a      = group_impact_reg;
                mul_b      = taken_next;
            end
            // saturating scenario sum, group closes
            S_ACC:
            begin
                if (sum_wide > ADD_W'(SUM_MAX))
                    scen_sum_next = SUM_MAX;
                else
                    scen_sum_next = sum_wide[SUM_W-1:0];
                remain_next     = remain_reg - taken_reg;
                group_open_next = 1'b0;
            end
            // open the group if needed and fold in this entry
            S_OPEN:
            begin
                mul_a = group_open_reg ? IMP_W'(group_miss_reg) : IMP_W'(PROB_ONE);
                mul_b = PROB_ONE - p_reg;
                if (!group_open_reg)
                begin
                    group_open_next   = 1'b1;
                    group_time_next   = t_reg;
                    group_impact_next = imp_reg;
                    group_miss_next   = PROB_ONE;
                    group_det_next    = 1'b0;
                end
                if (dummy_reg)
                begin
                    group_miss_next = '0;
                    group_det_next  = 1'b1;
                end
                if (!need_mul && last_reg)
                begin
                    final_next = 1'b1;
                    if (!open_det)
                        group_open_next = 1'b0;
                end
            end
            S_MISS:
            begin
                group_miss_next = prod_reg[PROB_FRAC_BITS +: PROB_W];
                group_det_next  = 1'b1;
                final_next      = last_reg;
            end
            // saturating batch total
            S_BATCH:
            begin
                if (batch_wide[TOTAL_W])
                    batch_sum_next = TOTAL_MAX;
                else
                    batch_sum_next = batch_wide[TOTAL_W-1:0];
            end
            // hand the result to the output register
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.scenario_impact = scen_sum_reg;
                    out_data_next.total_impact    = batch_sum_reg;
                    out_data_next.batch_done      = lscen_reg;
                    scen_sum_next                 = '0;
                    remain_next                   = PROB_ONE;
                    if (lscen_reg)
                        batch_sum_next = '0;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !out_ch.ready;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            final_reg        <= 1'b0;
            group_time_reg   <= '0;
            group_impact_reg <= '0;
            group_miss_reg   <= PROB_ONE;
            group_det_reg    <= 1'b0;
            group_open_reg   <= 1'b0;
            scen_sum_reg     <= '0;
            remain_reg       <= PROB_ONE;
            batch_sum_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            final_reg        <= final_next;
            group_time_reg   <= group_time_next;
            group_impact_reg <= group_impact_next;
            group_miss_reg   <= group_miss_next;
            group_det_reg    <= group_det_next;
            group_open_reg   <= group_open_next;
            scen_sum_reg     <= scen_sum_next;
            remain_reg       <= remain_next;
            batch_sum_reg    <= batch_sum_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        imp_reg      <= imp_next;
        p_reg        <= p_next;
        placed_reg   <= placed_next;
        dummy_reg    <= dummy_next;
        last_reg     <= last_next;
        lscen_reg    <= lscen_next;
        prod_reg     <= prod_next;
        taken_reg    <= taken_next;
        out_data_reg <= out_data_next;
    end

endmodule

/* bench/imperfect_sensor_expected_impact_test.sv */
// self-checking bench for the expected-impact block: directed entries, then random scenarios
// depends on isei_pkg, the channel interfaces in isei_if.sv and the top level
module imperfect_sensor_expected_impact_test;
    import isei_pkg::*;

    localparam int        QUIET_LIMIT = 2000;
    localparam int        DRAIN_CYCLES = 20;
    localparam int        RANDOM_ITEMS = 700;
    localparam bit [63:0] P_ONE = 64'(PROB_ONE);
    localparam bit [63:0] SUM_CEIL = 64'(SUM_MAX);

    // predictor of the scenario and batch sums, with the results still owed
    class impact_ledger;
        bit [63:0] grp_time;
        bit [63:0] grp_impact;
        bit [63:0] grp_miss;
        bit        grp_detect;
        bit        grp_open;
        bit [63:0] scen_sum;
        bit [63:0] remaining;
        bit [63:0] batch_total;
        out_item_t owed_results[$];
        int        mismatches;
        int        checked;

        function new();
            clear_group();
            scen_sum    = 0;
            remaining   = P_ONE;
            batch_total = 0;
            mismatches  = 0;
            checked     = 0;
        endfunction

        function void clear_group();
            grp_time   = 0;
            grp_impact = 0;
            grp_miss   = P_ONE;
            grp_detect = 1'b0;
            grp_open   = 1'b0;
        endfunction

        // fold a finished group into the scenario sum
        function void close_group();
            bit [63:0] miss;
            bit [63:0] detect;
            bit [63:0] taken;
            bit [63:0] add;
            if (grp_open && grp_detect)
            begin
                miss   = (grp_miss > P_ONE) ? P_ONE : grp_miss;
                detect = P_ONE - miss;
                taken  = (remaining * detect) >> PROB_FRAC_BITS;
                if (taken > remaining)
                    taken = remaining;
                add = grp_impact * taken;
                if (add > SUM_CEIL - scen_sum)
                    scen_sum = SUM_CEIL;
                else
                    scen_sum = scen_sum + add;
                remaining = remaining - taken;
            end
            clear_group();
        endfunction

        // accepted entry: advance the prediction, owe a result at scenario end
        function void note_entry(in_item_t e);
            bit [63:0] p;
            out_item_t r;
            p = 64'(e.detect_prob);
            if (p > P_ONE)
                p = P_ONE;
            if (grp_open && 64'(e.arrival_time) != grp_time)
                close_group();
            if (!grp_open)
            begin
                grp_open   = 1'b1;
                grp_time   = 64'(e.arrival_time);
                grp_impact = 64'(e.node_impact);
                grp_miss   = P_ONE;
                grp_detect = 1'b0;
            end
            if (e.is_dummy)
            begin
                grp_miss   = 0;
                grp_detect = 1'b1;
            end
            else if (e.sensor_placed)
            begin
                grp_miss   = (grp_miss * (P_ONE - p)) >> PROB_FRAC_BITS;
                grp_detect = 1'b1;
            end
            if (e.last_in_scenario)
            begin
                close_group();
                if (scen_sum > ~batch_total)
                    batch_total = '1;
                else
                    batch_total = batch_total + scen_sum;
                r.scenario_impact = scen_sum[SUM_W-1:0];
                r.total_impact    = batch_total;
                r.batch_done      = e.last_scenario;
                owed_results.insert(owed_results.size(), r);
                scen_sum  = 0;
                remaining = P_ONE;
                if (e.last_scenario)
                    batch_total = 0;
            end
        endfunction

        // compare one accepted result with the oldest one owed
        function void check_result(out_item_t got);
            out_item_t want;
            if (owed_results.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected result: expected none actual %h %h %b", $time,
                         got.scenario_impact, got.total_impact, got.batch_done);
                return;
            end
            want = owed_results.pop_front();
            checked++;
            if (got.scenario_impact !== want.scenario_impact)
            begin
                mismatches++;
                $display("%0t scenario_impact mismatch: expected %h actual %h", $time,
                         want.scenario_impact, got.scenario_impact);
            end
            if (got.total_impact !== want.total_impact)
            begin
                mismatches++;
                $display("%0t total_impact mismatch: expected %h actual %h", $time,
                         want.total_impact, got.total_impact);
            end
            if (got.batch_done !== want.batch_done)
            begin
                mismatches++;
                $display("%0t batch_done mismatch: expected %b actual %b", $time,
                         want.batch_done, got.batch_done);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    isei_in_if  in_ch();
    isei_out_if out_ch();

    imperfect_sensor_expected_impact dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    impact_ledger ledger = new();

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int quiet_cycles  = 0;
    int entries_sent  = 0;
    int scenarios_sent = 0;
    int batches_sent  = 0;

    // clock
    always #1 clk = ~clk;

    // result side: check accepted items, stall at random
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            ledger.check_result(out_ch.data);
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // watchdog
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    function automatic in_item_t make_entry(bit [31:0] t, bit [31:0] imp, bit [16:0] p,
                                            bit placed, bit dummy, bit last, bit last_scen);
        in_item_t e;
        e.arrival_time     = t;
        e.node_impact      = imp;
        e.detect_prob      = p;
        e.sensor_placed    = placed;
        e.is_dummy         = dummy;
        e.last_in_scenario = last;
        e.last_scenario    = last_scen;
        return e;
    endfunction

    // offer one entry, with an optional gap ahead of it, and wait for acceptance
    task automatic send_entry(input in_item_t e);
        if ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.data  <= e;
        in_ch.valid <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        ledger.note_entry(e);
        entries_sent++;
        if (e.last_in_scenario)
        begin
            scenarios_sent++;
            if (e.last_scenario)
                batches_sent++;
        end
    endtask

    // one random scenario: groups of equal time, occasional jumps back
    task automatic run_scenario(input bit end_batch);
        int        n;
        int        r;
        bit [31:0] t;
        bit [31:0] imp;
        bit [16:0] p;
        bit        last;
        n = $urandom_range(1, 8);
        t = $urandom;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (i != 0)
            begin
                if (r >= 90)
                    t = $urandom;
                else if (r >= 45)
                    t = t + $urandom_range(1, 1000);
            end
            r = $urandom_range(99);
            if (r < 10)
                imp = '1;
            else if (r < 15)
                imp = 0;
            else
                imp = $urandom;
            r = $urandom_range(99);
            if (r < 10)
                p = 0;
            else if (r < 20)
                p = PROB_ONE;
            else if (r < 30)
                p = 17'($urandom_range(65537, 131071));
            else
                p = 17'($urandom_range(0, 65536));
            last = (i == n - 1);
            send_entry(make_entry(t, imp, p, $urandom_range(99) < 65, $urandom_range(99) < 8,
                                  last, last ? end_batch : ($urandom_range(9) == 0)));
        end
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct, input int items);
        int stop_at;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        stop_at        = entries_sent + items;
        while (entries_sent < stop_at)
            run_scenario($urandom_range(4) == 0);
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: dummy alone with the largest impact
        send_entry(make_entry(32'd0, 32'hFFFF_FFFF, 17'd0, 1'b0, 1'b1, 1'b1, 1'b0));
        // one group: half, above-one probability, sensor on the dummy
        send_entry(make_entry(32'd5, 32'd1000, 17'd32768, 1'b1, 1'b0, 1'b0, 1'b0));
        send_entry(make_entry(32'd5, 32'd7, 17'h1FFFF, 1'b1, 1'b0, 1'b0, 1'b0));
        send_entry(make_entry(32'd5, 32'd9, 17'd100, 1'b1, 1'b1, 1'b0, 1'b0));
        // entry that detects nothing, then time going back with a stray last-scenario flag
        send_entry(make_entry(32'd9, 32'd50, 17'd40000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_entry(make_entry(32'd3, 32'd123, 17'd65535, 1'b1, 1'b0, 1'b0, 1'b1));
        send_entry(make_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd1, 1'b1, 1'b0, 1'b1, 1'b1));
        // lone entry without a detector closes a scenario with zero
        send_entry(make_entry(32'd100, 32'd77, 17'h1FFFF, 1'b0, 1'b0, 1'b1, 1'b0));
        // certain sensor, then a later dummy that finds nothing left
        send_entry(make_entry(32'd10, 32'h8000_0000, PROB_ONE, 1'b1, 1'b0, 1'b0, 1'b0));
        send_entry(make_entry(32'd11, 32'hFFFF_FFFF, 17'd0, 1'b0, 1'b1, 1'b1, 1'b0));
        // small, near-one and above-one probabilities chained over groups
        send_entry(make_entry(32'd20, 32'd5000, 17'd1, 1'b1, 1'b0, 1'b0, 1'b0));
        send_entry(make_entry(32'd20, 32'h7FFF_FFFF, 17'd65535, 1'b1, 1'b0, 1'b0, 1'b0));
        send_entry(make_entry(32'd21, 32'h0001_0000, 17'h10001, 1'b1, 1'b0, 1'b0, 1'b0));
        send_entry(make_entry(32'd22, 32'hFFFF_FFFF, 17'd0, 1'b1, 1'b0, 1'b0, 1'b0));
        send_entry(make_entry(32'd0, 32'd1, 17'd21845, 1'b1, 1'b0, 1'b1, 1'b1));
        // two back-to-back single-entry scenarios, the second ending a batch
        send_entry(make_entry(32'hFFFF_FFFF, 32'd0, PROB_ONE, 1'b1, 1'b1, 1'b1, 1'b0));
        send_entry(make_entry(32'h0000_0001, 32'h5555_AAAA, 17'd12345, 1'b1, 1'b0, 1'b1, 1'b1));

        // random scenarios under three pacing regimes
        run_phase(8, 67, RANDOM_ITEMS / 3);
        run_phase(67, 8, RANDOM_ITEMS / 3);
        run_phase(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        in_ch.valid <= 1'b0;
        while (ledger.owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d entries in %0d scenarios over %0d batches; %0d results checked",
                 entries_sent, scenarios_sent, batches_sent, ledger.checked);
        $display("%0d field mismatches, %0d results still owed",
                 ledger.mismatches, ledger.owed_results.size());
        if (ledger.mismatches == 0 && ledger.owed_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* imperfect_sensor_expected_impact.f */
hdl/isei_pkg.sv
hdl/isei_if.sv
hdl/imperfect_sensor_expected_impact.sv
bench/imperfect_sensor_expected_impact_test.sv
